// File: sv/jher_pkg.sv
// ----------------------------------------------------------------------------
// jher_pkg: shared types and constants of the JSON hex escape rewriter
// Holds the scan state encoding, the byte run type handed from the decoder
// to the output stage, and the six byte escape sequences.
// ----------------------------------------------------------------------------
package jher_pkg;

  // Scan state of the escape tracker.
  typedef enum logic [1:0] {
    SCAN_NORMAL = 2'd0,
    SCAN_HELD   = 2'd1,
    SCAN_HEX    = 2'd2
  } scan_mode_e;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TAG  = 2'd0;
  localparam logic [1:0] REG_AMP  = 2'd1;
  localparam logic [1:0] REG_APOS = 2'd2;
  localparam logic [1:0] REG_QUOT = 2'd3;

  localparam int unsigned RunMax = 6;

  typedef logic [7:0] byte_t;
  // Byte 0 goes out first.
  typedef byte_t [RunMax-1:0] seq_t;

  // Escape sequences, written last byte first.
  localparam seq_t ESC_QUOT = {"2", "2", "0", "0", "u", "\\"};
  localparam seq_t ESC_LT   = {"C", "3", "0", "0", "u", "\\"};
  localparam seq_t ESC_GT   = {"E", "3", "0", "0", "u", "\\"};
  localparam seq_t ESC_AMP  = {"6", "2", "0", "0", "u", "\\"};
  localparam seq_t ESC_APOS = {"7", "2", "0", "0", "u", "\\"};

  // One run of output bytes caused by one input transaction.
  typedef struct packed {
    seq_t       bytes;
    logic [2:0] len;
    logic       fin;
  } run_t;

  // Substitution mode bits.
  typedef struct packed {
    logic tag;
    logic amp;
    logic apos;
    logic quot;
  } modes_t;

endpackage

// File: sv/jher_decode.sv
// ----------------------------------------------------------------------------
// jher_decode: escape tracker and run builder
// Turns one input byte into a run of zero to six output bytes and keeps the
// backslash and hex digit tracking state between transactions.
// ----------------------------------------------------------------------------
module jher_decode
  import jher_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  input  modes_t     modes_i,
  output run_t       run_o
);

  scan_mode_e scan_mode_q, scan_mode_d;
  logic [2:0] hex_left_q, hex_left_d;

  // Build the run and the next scan state.
  always_comb begin
    run_o       = '0;
    run_o.fin   = in_final_i;
    scan_mode_d = scan_mode_q;
    hex_left_d  = hex_left_q;
    if (scan_mode_q == SCAN_HELD) begin
      if (modes_i.quot && in_byte_i == "\"") begin
        run_o.bytes = ESC_QUOT;
        run_o.len   = 3'd6;
        scan_mode_d = SCAN_NORMAL;
      end else begin
        run_o.bytes[0] = "\\";
        run_o.bytes[1] = in_byte_i;
        run_o.len      = 3'd2;
        if (in_byte_i == "u") begin
          scan_mode_d = SCAN_HEX;
          hex_left_d  = 3'd4;
        end else begin
          scan_mode_d = SCAN_NORMAL;
        end
      end
    end else if (scan_mode_q == SCAN_HEX && hex_left_q != 3'd0) begin
      run_o.bytes[0] = in_byte_i;
      run_o.len      = 3'd1;
      hex_left_d     = hex_left_q - 3'd1;
      if (hex_left_q == 3'd1) begin
        scan_mode_d = SCAN_NORMAL;
      end
    end else begin
      scan_mode_d = SCAN_NORMAL;
      hex_left_d  = 3'd0;
      if (in_byte_i == "\\") begin
        if (in_final_i) begin
          run_o.bytes[0] = in_byte_i;
          run_o.len      = 3'd1;
        end else begin
          scan_mode_d = SCAN_HELD;
        end
      end else if (modes_i.tag && in_byte_i == "<") begin
        run_o.bytes = ESC_LT;
        run_o.len   = 3'd6;
      end else if (modes_i.tag && in_byte_i == ">") begin
        run_o.bytes = ESC_GT;
        run_o.len   = 3'd6;
      end else if (modes_i.amp && in_byte_i == "&") begin
        run_o.bytes = ESC_AMP;
        run_o.len   = 3'd6;
      end else if (modes_i.apos && in_byte_i == "'") begin
        run_o.bytes = ESC_APOS;
        run_o.len   = 3'd6;
      end else begin
        run_o.bytes[0] = in_byte_i;
        run_o.len      = 3'd1;
      end
    end
    // The end of a region returns the tracker to its reset state.
    if (in_final_i) begin
      scan_mode_d = SCAN_NORMAL;
      hex_left_d  = 3'd0;
    end
  end

  // State registers advance only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q <= SCAN_NORMAL;
      hex_left_q  <= 3'd0;
    end else if (accept_i) begin
      scan_mode_q <= scan_mode_d;
      hex_left_q  <= hex_left_d;
    end
  end

endmodule

// File: sv/json_hex_escape_rewriter_top.sv
// ----------------------------------------------------------------------------
// json_hex_escape_rewriter_top: HTML-safe hex escape rewriter for JSON text
// Rewrites the bytes of an escaped JSON string region, replacing selected
// characters and escaped quotes with \u00XX sequences.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) takes one byte per transaction
//   with in_final_i marking the last byte of a region. The output channel
//   (out_valid_o/out_ready_i) delivers rewritten bytes; run_end_o marks the
//   last byte caused by one input and region_end_o the last byte of a region.
//   Substitution modes are set over the APB port while the block is idle.
//   An accepted byte is decoded into the run register when it is accepted,
//   then moves on to the output shift register, which offers its first byte.
//   Throughput: one input per cycle while each input yields one byte and the
//   receiver takes every byte. An input yields up to six bytes, and the output
//   shift register sends one byte per cycle while the receiver is ready, so a
//   substitution holds the input back until its bytes have drained.
//   A backslash that opens an escape and does not end a region yields no byte
//   by itself; it is folded into the next run.
//   When the receiver stalls, the output byte holds and one further decoded
//   run waits in the run register before in_ready_o drops.
//   Reset clears the modes, the escape tracker and both stages.
// ----------------------------------------------------------------------------
module json_hex_escape_rewriter_top
  import jher_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_final_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_end_o,
  output logic        region_end_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  modes_t     modes_q;
  run_t       dec_run;
  run_t       run_q;
  logic       run_valid_q;
  seq_t       buf_q;
  logic [2:0] rem_q;
  logic       fin_q;
  logic       in_accept;
  logic       em_load;
  logic       out_accept;
  logic       cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_TAG:  modes_q.tag  <= pwdata[0];
        REG_AMP:  modes_q.amp  <= pwdata[0];
        REG_APOS: modes_q.apos <= pwdata[0];
        REG_QUOT: modes_q.quot <= pwdata[0];
        default:  modes_q      <= modes_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_TAG:  prdata[0] = modes_q.tag;
      REG_AMP:  prdata[0] = modes_q.amp;
      REG_APOS: prdata[0] = modes_q.apos;
      REG_QUOT: prdata[0] = modes_q.quot;
      default:  prdata    = '0;
    endcase
  end

  // Handshake control between the run register and the output stage.
  assign out_accept = out_valid_o && out_ready_i;
  assign em_load    = run_valid_q && (rem_q == 3'd0 || (rem_q == 3'd1 && out_ready_i));
  assign in_ready_o = !run_valid_q || em_load;
  assign in_accept  = in_valid_i && in_ready_o;

  jher_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .in_byte_i  (in_byte_i),
    .in_final_i (in_final_i),
    .modes_i    (modes_q),
    .run_o      (dec_run)
  );

  // Run register: holds one decoded run; empty runs are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
    end else if (in_accept) begin
      run_valid_q <= (dec_run.len != 3'd0);
    end else if (em_load) begin
      run_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      run_q <= dec_run;
    end
  end

  // Output shift register: sends byte 0 and shifts down by one byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else if (em_load) begin
      rem_q <= run_q.len;
    end else if (out_accept) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load) begin
      buf_q <= run_q.bytes;
      fin_q <= run_q.fin;
    end else if (out_accept) begin
      buf_q <= buf_q >> 8;
    end
  end

  assign out_valid_o  = (rem_q != 3'd0);
  assign out_byte_o   = buf_q[0];
  assign run_end_o    = (rem_q == 3'd1);
  assign region_end_o = (rem_q == 3'd1) && fin_q;

  // A run never holds more bytes than the longest escape sequence.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd6)
    else $error("output run length out of range");

  // A pending run that cannot move stays pending.
  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q && !em_load |=> run_valid_q)
    else $error("pending run lost");

  // A new run is loaded only after the previous one has fully drained.
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_load |-> (rem_q == 3'd0) || (out_accept && run_end_o))
    else $error("run loaded over undelivered bytes");

  // With the run register empty, input is always taken.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_valid_q |-> in_ready_o)
    else $error("input stalled with empty run register");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for json_hex_escape_rewriter_top
// Sends escaped JSON byte regions through the rewriter under several
// substitution mode settings. A scoreboard predicts every output byte and
// its run and region flags, and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import jher_pkg::*;

  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned NumRandPhases = 5;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned HoldCycles    = 64;
  localparam int unsigned TimeoutCycles = 400_000;

  // Characters that the rewriter treats specially.
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_LT     = 8'h3C;
  localparam byte_t CH_GT     = 8'h3E;
  localparam byte_t CH_AMP    = 8'h26;
  localparam byte_t CH_APOS   = 8'h27;
  localparam byte_t CH_U      = 8'h75;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_DENSE
  } rx_pattern_e;

  typedef struct {
    byte_t data;
    logic  fin;
  } stim_t;

  typedef struct {
    byte_t data;
    logic  run_end;
    logic  region_end;
  } beat_t;

  // Predicts the rewritten byte stream and checks the output against it.
  class escape_scoreboard;
    modes_t      modes;
    scan_mode_e  scan;
    logic [2:0]  digits_left;
    beat_t       expected_q[$];
    int unsigned mismatches;
    int unsigned inputs_seen;
    int unsigned outputs_seen;
    int unsigned substitutions;
    int unsigned regions;

    function new();
      modes       = '0;
      scan        = SCAN_NORMAL;
      digits_left = '0;
      mismatches  = 0;
    endfunction

    function void set_mode(logic [1:0] idx, logic val);
      case (idx)
        REG_TAG:  modes.tag  = val;
        REG_AMP:  modes.amp  = val;
        REG_APOS: modes.apos = val;
        REG_QUOT: modes.quot = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Works out the run of output bytes caused by one input transaction.
    function void note_input(byte_t c, logic fin);
      byte_t run[$];
      seq_t  subst;
      logic  use_subst;
      beat_t b;
      use_subst = 1'b0;
      subst     = '0;
      inputs_seen++;
      if (scan == SCAN_HELD) begin
        if (modes.quot && c == CH_QUOTE) begin
          subst     = ESC_QUOT;
          use_subst = 1'b1;
          scan      = SCAN_NORMAL;
        end else begin
          run.push_back(CH_BSLASH);
          run.push_back(c);
          if (c == CH_U) begin
            scan        = SCAN_HEX;
            digits_left = 3'd4;
          end else begin
            scan = SCAN_NORMAL;
          end
        end
      end else if (scan == SCAN_HEX && digits_left != 0) begin
        // Hex digits of a \u escape pass through untouched.
        run.push_back(c);
        digits_left = digits_left - 3'd1;
        if (digits_left == 0) scan = SCAN_NORMAL;
      end else begin
        scan        = SCAN_NORMAL;
        digits_left = '0;
        if (c == CH_BSLASH) begin
          if (fin) run.push_back(c);
          else scan = SCAN_HELD;
        end else if (modes.tag && c == CH_LT) begin
          subst     = ESC_LT;
          use_subst = 1'b1;
        end else if (modes.tag && c == CH_GT) begin
          subst     = ESC_GT;
          use_subst = 1'b1;
        end else if (modes.amp && c == CH_AMP) begin
          subst     = ESC_AMP;
          use_subst = 1'b1;
        end else if (modes.apos && c == CH_APOS) begin
          subst     = ESC_APOS;
          use_subst = 1'b1;
        end else begin
          run.push_back(c);
        end
      end

      if (use_subst) begin
        substitutions++;
        for (int k = 0; k < RunMax; k++) run.push_back(subst[k]);
      end

      // The end of a region returns the escape tracker to its reset state.
      if (fin) begin
        scan        = SCAN_NORMAL;
        digits_left = '0;
        if (run.size() > 0) regions++;
      end

      foreach (run[k]) begin
        b.data       = run[k];
        b.run_end    = (k == run.size() - 1);
        b.region_end = (k == run.size() - 1) && fin;
        expected_q.push_back(b);
      end
    endfunction

    // Compares one output transaction with the oldest expectation.
    function void check_result(byte_t data, logic run_end, logic region_end);
      beat_t e;
      outputs_seen++;
      if (expected_q.size() == 0) begin
        $error("out_byte: no output expected, got %h", data);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $error("out_byte: expected %h, actual %h", e.data, data);
        mismatches++;
      end
      if (run_end !== e.run_end) begin
        $error("run_end: expected %b, actual %b", e.run_end, run_end);
        mismatches++;
      end
      if (region_end !== e.region_end) begin
        $error("region_end: expected %b, actual %b", e.region_end, region_end);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        in_final_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        run_end_o;
  logic        region_end_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  escape_scoreboard sb = new();
  stim_t            stim_q[$];
  bit               hold_req;
  int unsigned      settings_used;

  json_hex_escape_rewriter_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_final_i   (in_final_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .region_end_o (region_end_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_byte_i, in_final_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_byte_o, run_end_o, region_end_o);
    end
  end

  // Receiver: random stall patterns, with one long hold on request.
  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned seg_left;
    int unsigned hold_left;
    out_ready_i = 1'b0;
    seg_left    = 0;
    hold_left   = 0;
    pattern     = RX_OPEN;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          pattern  = rx_pattern_e'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (pattern)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Run limit.
  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("** json_hex_escape_rewriter_top: FAILED **");
    $finish;
  end

  // One register write over APB: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, logic val);
    logic [31:0] wdata;
    wdata    = $urandom();
    wdata[0] = val;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_mode(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_modes(modes_t m);
    write_reg(REG_TAG, m.tag);
    write_reg(REG_AMP, m.amp);
    write_reg(REG_APOS, m.apos);
    write_reg(REG_QUOT, m.quot);
    settings_used++;
  endtask

  function automatic void push_item(byte_t data, logic fin);
    stim_t s;
    s.data = data;
    s.fin  = fin;
    stim_q.push_back(s);
  endfunction

  function automatic byte_t hex_digit();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return byte_t'(8'h30 + v);
    return byte_t'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + (v - 10));
  endfunction

  // Appends one random piece of escaped JSON text, mostly well formed.
  task automatic add_token();
    int unsigned pick;
    int unsigned n;
    logic        fin;
    byte_t       esc_chars[8];
    byte_t       specials[4];
    esc_chars = '{CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_BSLASH, 8'h2F, 8'h6E, 8'h74, 8'h62};
    specials  = '{CH_LT, CH_GT, CH_AMP, CH_APOS};
    fin       = ($urandom_range(0, 15) == 0);
    pick      = $urandom_range(0, 99);
    if (pick < 35) begin
      push_item(byte_t'($urandom_range(8'h20, 8'h7E)), fin);
    end else if (pick < 55) begin
      push_item(specials[$urandom_range(0, 3)], fin);
    end else if (pick < 72) begin
      push_item(CH_BSLASH, 1'b0);
      push_item(esc_chars[$urandom_range(0, 7)], fin);
    end else if (pick < 84) begin
      // Full \u escape; the digits are sometimes arbitrary bytes.
      push_item(CH_BSLASH, 1'b0);
      push_item(CH_U, 1'b0);
      for (int k = 0; k < 4; k++) begin
        push_item(($urandom_range(0, 4) == 0) ? byte_t'($urandom_range(0, 255)) : hex_digit(),
                  (k == 3) && fin);
      end
    end else if (pick < 89) begin
      // Region ends inside a \u escape.
      n = $urandom_range(0, 3);
      push_item(CH_BSLASH, 1'b0);
      push_item(CH_U, n == 0);
      for (int k = 0; k < n; k++) push_item(hex_digit(), k == n - 1);
    end else if (pick < 92) begin
      push_item(CH_BSLASH, 1'b1);
    end else begin
      push_item(byte_t'($urandom_range(0, 255)), fin);
    end
  endtask

  // Sender: offers queued items in bursts with random gaps.
  task automatic send_items();
    stim_t       s;
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(1, 24);
    while (stim_q.size() > 0) begin
      s = stim_q.pop_front();
      @(negedge clk_i);
      in_valid_i <= 1'b1;
      in_byte_i  <= s.data;
      in_final_i <= s.fin;
      do @(posedge clk_i); while (!in_ready_o);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits for every expected byte, then lets the pipeline settle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Main sequence.
  initial begin : main_seq
    string  directed;
    modes_t m;
    stim_t  last;
    int     p;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = '0;
    in_final_i    = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    settings_used = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every substitution, an escaped quote, \u with special
    // characters as digits, plain escapes, byte extremes, a region cut
    // short inside \u and a backslash that ends the region.
    apply_modes('1);
    directed = "<>&'\\\"\\u<&'\"\\n\\/";
    for (int k = 0; k < directed.len(); k++) push_item(directed[k], 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(CH_BSLASH, 1'b0);
    push_item(CH_U, 1'b0);
    push_item(8'h34, 1'b1);
    push_item(CH_BSLASH, 1'b1);
    send_items();
    wait_idle();

    // Random phases: all modes off, all on, then random settings.
    for (p = 0; p < NumRandPhases; p++) begin
      case (p)
        0:       m = '0;
        1:       m = '1;
        default: m = modes_t'($urandom_range(0, 15));
      endcase
      apply_modes(m);
      while (stim_q.size() < ItemsPerPhase) add_token();
      last     = stim_q.pop_back();
      last.fin = 1'b1;
      stim_q.push_back(last);
      if (p == 2) hold_req = 1'b1;
      send_items();
      wait_idle();
    end

    $display("Run covered %0d input and %0d output transactions under %0d mode settings.",
             sb.inputs_seen, sb.outputs_seen, settings_used);
    $display("It saw %0d hex substitutions and %0d completed regions.",
             sb.substitutions, sb.regions);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** json_hex_escape_rewriter_top: PASSED **");
    end else begin
      $display("** json_hex_escape_rewriter_top: FAILED **");
    end
    $finish;
  end

endmodule
